>>> src/scah_pkg.sv
// ----------------------------------------------------------------------------
// scah_pkg
// Shared types, constants and helper functions of the scan corridor angle
// histogram block.
// ----------------------------------------------------------------------------
package scah_pkg;

  localparam int NUM_BINS_DEF   = 180;
  localparam int MAX_OFFSET_DEF = 16;
  localparam int RANGE_BITS_DEF = 16;

  localparam int CORDIC_ITERS = 16;
  localparam int ITW          = $clog2(CORDIC_ITERS);
  localparam int ZW           = 18;
  localparam int GAIN_INV     = 39797;
  localparam int DENOISE_DIV  = 20;
  localparam int FRAC_ONE     = 256;

  localparam logic signed [ZW-1:0] QUARTER_Z = 18'sd16384;
  localparam logic signed [ZW-1:0] HALF_Z    = 18'sd32768;

  localparam logic [1:0] REG_RANGE_WEIGHTED  = 2'd0;
  localparam logic [1:0] REG_PAIR_OFFSET     = 2'd1;
  localparam logic [1:0] REG_PEAK_HALF_WIDTH = 2'd2;
  localparam logic [1:0] REG_MIN_PEAK_FRAC   = 2'd3;

  typedef struct packed {
    logic [15:0]        range_mm;
    logic signed [15:0] bearing;
    logic               point_valid;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic        corridor_like;
    logic [7:0]  peak_bin;
    logic [31:0] peak_weight;
    logic [31:0] total_weight;
    logic        too_few_points;
  } out_t;

  typedef enum logic {
    CM_ROTATE,
    CM_VECTOR
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ROT,
    S_ROT_WAIT,
    S_GAIN_X,
    S_GAIN_Y,
    S_GAIN_END,
    S_RD_OLD,
    S_RD_MID,
    S_VEC,
    S_VEC_WAIT,
    S_BIN,
    S_HIST_RD,
    S_HIST_WR,
    S_STORE,
    S_END,
    S_MAX,
    S_TOTAL,
    S_PEAK,
    S_SMOOTH,
    S_DECIDE,
    S_OUT
  } state_e;

  function automatic logic signed [ZW-1:0] atan_val(input logic [ITW-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      4'd14:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> src/scah_cordic.sv
// ----------------------------------------------------------------------------
// scah_cordic
// Shared iterative CORDIC unit, one micro-rotation per cycle, used both for
// polar to Cartesian rotation and for angle vectoring.
// ----------------------------------------------------------------------------
module scah_cordic #(
  parameter int CW = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scah_pkg::cordic_ctl_t         ctl_i,
  input  logic signed [CW-1:0]          x_i,
  input  logic signed [CW-1:0]          y_i,
  input  logic signed [scah_pkg::ZW-1:0] z_i,
  output scah_pkg::cordic_sts_t         sts_o,
  output logic signed [CW-1:0]          x_o,
  output logic signed [CW-1:0]          y_o,
  output logic signed [scah_pkg::ZW-1:0] z_o
);
  import scah_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [ITW-1:0]        iter_q, iter_d;
  cordic_mode_e          mode_q, mode_d;
  logic signed [CW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]  z_q, z_d;
  logic signed [CW-1:0]  xs, ys;
  logic                  pos;

  always_comb begin
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    pos = (mode_q == CM_ROTATE) ? (z_q >= 0) : (y_q < 0);
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    mode_d = mode_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      iter_d = '0;
      mode_d = ctl_i.mode;
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (busy_q) begin
      if (pos) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_val(iter_q);
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_val(iter_q);
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == ITW'(CORDIC_ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      mode_q <= CM_ROTATE;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> src/scan_corridor_angle_histogram_core.sv
// ----------------------------------------------------------------------------
// scan_corridor_angle_histogram_core
// Laser scan corridor detector: pairwise direction histogram and peak test.
// ----------------------------------------------------------------------------
// A valid point makes a 16-step pass through the shared CORDIC unit for its
// position and gain scaling; with a pair partner, delay line reads, a second
// 16-step pass for the pair direction (none for a zero difference) and one
// histogram read-modify-write follow. A point that is not valid and ends no
// scan causes no stall. A scan end with a pair adds four walks over the single
// histogram read port, after which one result transfer is offered. The input is
// stalled while a point is in work, and the histogram is empty again at result load.
module scan_corridor_angle_histogram_core
  import scah_pkg::*;
#(
  parameter int NUM_BINS   = scah_pkg::NUM_BINS_DEF,
  parameter int MAX_OFFSET = scah_pkg::MAX_OFFSET_DEF,
  parameter int RANGE_BITS = scah_pkg::RANGE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  scah_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output scah_pkg::out_t      out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int BW    = $clog2(NUM_BINS);
  localparam int CNTW  = $clog2(NUM_BINS + 3);
  localparam int AW    = (MAX_OFFSET > 1) ? $clog2(MAX_OFFSET) : 1;
  localparam int SW    = $clog2(MAX_OFFSET + 1);
  localparam int MW    = RANGE_BITS + 2;
  localparam int DW    = RANGE_BITS + 3;
  localparam int CW    = RANGE_BITS + 9;
  localparam int PW    = CW + 17;
  localparam int EW    = RANGE_BITS + 2 * MW;
  localparam int HWMAX = (NUM_BINS - 1) / 2;
  localparam int ZPW   = ZW + BW;

  localparam logic signed [PW-1:0] GAIN_S = PW'(GAIN_INV);
  localparam logic signed [PW-1:0] RND_S  = PW'(1 << 17);
  localparam logic signed [PW-1:0] LIM_S  = PW'((1 << (RANGE_BITS + 1)) - 1);

  state_e               state_q, state_d;
  logic                 rw_q;
  logic [4:0]           po_q;
  logic [6:0]           phw_q;
  logic [8:0]           mpf_q;
  logic [SW-1:0]        seen_q, seen_d;
  logic                 pair_q, pair_d;
  logic [AW-1:0]        wp_q, wp_d;
  logic [NUM_BINS-1:0]  hvalid_q;
  logic                 out_valid_q, out_valid_d;
  logic                 pend_q, pend_d;

  in_t                  in_q, in_d;
  out_t                 out_data_q, out_data_d, res_q, res_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [MW-1:0] xmm_q, xmm_d, ymm_q, ymm_d;
  logic signed [DW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [RANGE_BITS-1:0] vote_q, vote_d;
  logic [BW-1:0]        bin_q, bin_d;
  logic [CNTW-1:0]      cnt_q, cnt_d, pidx_q, pidx_d;
  logic [BW-1:0]        addr_q, addr_d, baddr_q, baddr_d;
  logic [31:0]          maxv_q, maxv_d, total_q, total_d, peak_q, peak_d;
  logic [31:0]          w1_q, w1_d, w2_q, w2_d;
  logic [33:0]          best_q, best_d;
  logic [BW-1:0]        mi_q, mi_d, bi_q, bi_d;

  logic [31:0]          hist_mem [NUM_BINS];
  logic [31:0]          h_rd_q;
  logic                 hv_rd_q;
  logic [BW-1:0]        h_raddr;
  logic                 h_we, hclr;
  logic [31:0]          h_wdata;

  logic [EW-1:0]        dl_mem [MAX_OFFSET];
  logic [EW-1:0]        dl_rd_q;
  logic [AW-1:0]        dl_raddr;
  logic                 dl_we;

  cordic_ctl_t          cc;
  cordic_sts_t          cs;
  logic signed [CW-1:0] c_xi, c_yi, c_xo, c_yo;
  logic signed [ZW-1:0] c_zi, c_zo;

  logic [6:0]           po7;
  logic [SW-1:0]        w_eff, mid_k;
  logic [7:0]           old_t, mid_t;
  logic [AW-1:0]        old_addr, mid_addr;
  logic [RANGE_BITS-1:0] rng;
  logic signed [ZW-1:0] bz, rz, vz;
  logic signed [CW-1:0] bx, rx, vx, vy, x16, y16;
  logic signed [DW-1:0] fx, fy;
  logic                 vneg;
  logic signed [PW-1:0] mm_t;
  logic signed [MW-1:0] mm_c;
  logic signed [ZW-1:0] zc;
  logic [ZPW-1:0]       zp;
  logic [RANGE_BITS-1:0] old_rng, mid_rng;
  logic signed [MW-1:0] old_x, old_y;
  logic [31:0]          h_eff, hf;
  logic [36:0]          h20;
  logic [33:0]          ssum;
  logic [8:0]           phw9;
  logic [BW-1:0]        hw_eff;
  logic [BW:0]          ps;
  logic [BW-1:0]        peak_start;
  logic                 walk;
  logic [CNTW-1:0]      walk_len;
  logic [8:0]           frac;
  logic [40:0]          lhs, rhs;

  scah_cordic #(.CW(CW)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cc),
    .x_i    (c_xi),
    .y_i    (c_yi),
    .z_i    (c_zi),
    .sts_o  (cs),
    .x_o    (c_xo),
    .y_o    (c_yo),
    .z_o    (c_zo)
  );

  always_comb begin
    po7 = 7'(po_q);
    if (po7 == 7'd0) begin
      w_eff = SW'(1);
    end else if (po7 > 7'(MAX_OFFSET)) begin
      w_eff = SW'(MAX_OFFSET);
    end else begin
      w_eff = SW'(po7);
    end
    mid_k = w_eff - (w_eff >> 1);
    old_t = 8'(wp_q) + 8'(MAX_OFFSET) - 8'(w_eff);
    if (old_t >= 8'(MAX_OFFSET)) begin
      old_t = old_t - 8'(MAX_OFFSET);
    end
    mid_t = 8'(wp_q) + 8'(MAX_OFFSET) - 8'(mid_k);
    if (mid_t >= 8'(MAX_OFFSET)) begin
      mid_t = mid_t - 8'(MAX_OFFSET);
    end
    old_addr = old_t[AW-1:0];
    mid_addr = mid_t[AW-1:0];

    rng = RANGE_BITS'(in_q.range_mm);
    bz = ZW'(in_q.bearing);
    bx = $signed(CW'({rng, 2'b00}));
    rz = bz;
    rx = bx;
    if (bz > QUARTER_Z) begin
      rz = bz - HALF_Z;
      rx = -bx;
    end else if (bz < -QUARTER_Z) begin
      rz = bz + HALF_Z;
      rx = -bx;
    end

    vneg = (dy_q < 0) || ((dy_q == 0) && (dx_q < 0));
    fx = vneg ? -dx_q : dx_q;
    fy = vneg ? -dy_q : dy_q;
    x16 = CW'(fx) <<< 4;
    y16 = CW'(fy) <<< 4;
    if (x16 < 0) begin
      vx = y16;
      vy = -x16;
      vz = QUARTER_Z;
    end else begin
      vx = x16;
      vy = y16;
      vz = '0;
    end

    mm_t = (prod_q + RND_S) >>> 18;
    if (mm_t > LIM_S) begin
      mm_c = MW'(LIM_S);
    end else if (mm_t < -LIM_S) begin
      mm_c = MW'(-LIM_S);
    end else begin
      mm_c = MW'(mm_t);
    end

    zc = (c_zo < 0) ? '0 : c_zo;
    zp = ZPW'(zc) * ZPW'(NUM_BINS) + ZPW'(16384);
    zp = zp >> 15;

    old_rng = dl_rd_q[EW-1 -: RANGE_BITS];
    old_x   = $signed(dl_rd_q[2*MW-1 -: MW]);
    old_y   = $signed(dl_rd_q[MW-1:0]);
    mid_rng = old_rng;

    h_eff = hv_rd_q ? h_rd_q : 32'd0;
    h20 = 37'(h_eff) * 37'(DENOISE_DIV);
    hf = (h20 < 37'(maxv_q)) ? 32'd0 : h_eff;
    ssum = 34'(w1_q) + 34'(w2_q) + 34'(hf);

    phw9 = 9'(phw_q);
    hw_eff = (phw9 > 9'(HWMAX)) ? BW'(HWMAX) : BW'(phw_q);
    ps = {1'b0, mi_q} + (BW+1)'(NUM_BINS) - {1'b0, hw_eff};
    if (ps >= (BW+1)'(NUM_BINS)) begin
      ps = ps - (BW+1)'(NUM_BINS);
    end
    peak_start = ps[BW-1:0];

    frac = (mpf_q > 9'(FRAC_ONE)) ? 9'(FRAC_ONE) : mpf_q;
    lhs = {1'b0, peak_q, 8'd0};
    rhs = 41'(frac) * 41'(total_q);
  end

  always_comb begin
    walk = (state_q == S_MAX) || (state_q == S_TOTAL) || (state_q == S_PEAK) ||
           (state_q == S_SMOOTH);
    unique case (state_q)
      S_PEAK:   walk_len = (maxv_q == 32'd0) ? '0 : CNTW'({hw_eff, 1'b1});
      S_SMOOTH: walk_len = CNTW'(NUM_BINS + 2);
      default:  walk_len = CNTW'(NUM_BINS);
    endcase
  end

  always_comb begin
    state_d = state_q;
    seen_d = seen_q;
    pair_d = pair_q;
    wp_d = wp_q;
    out_valid_d = out_valid_q && out_stall_i;
    pend_d = 1'b0;
    in_d = in_q;
    out_data_d = out_data_q;
    res_d = res_q;
    prod_d = prod_q;
    xmm_d = xmm_q;
    ymm_d = ymm_q;
    dx_d = dx_q;
    dy_d = dy_q;
    vote_d = vote_q;
    bin_d = bin_q;
    cnt_d = cnt_q;
    pidx_d = pidx_q;
    addr_d = addr_q;
    baddr_d = baddr_q;
    maxv_d = maxv_q;
    total_d = total_q;
    peak_d = peak_q;
    w1_d = w1_q;
    w2_d = w2_q;
    best_d = best_q;
    mi_d = mi_q;
    bi_d = bi_q;
    cc.start = 1'b0;
    cc.mode = CM_ROTATE;
    c_xi = rx;
    c_yi = '0;
    c_zi = rz;
    h_raddr = bin_q;
    h_we = 1'b0;
    h_wdata = sat_add32(h_eff, 32'(vote_q));
    hclr = 1'b0;
    dl_raddr = old_addr;
    dl_we = 1'b0;

    if (walk) begin
      if (cnt_q < walk_len) begin
        h_raddr = addr_q;
        addr_d = (addr_q == BW'(NUM_BINS - 1)) ? '0 : addr_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
        pend_d = 1'b1;
        pidx_d = cnt_q;
        baddr_d = addr_q;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d = in_data_i;
          if (in_data_i.point_valid) begin
            state_d = S_ROT;
          end else if (in_data_i.last_point) begin
            state_d = S_END;
          end
        end
      end
      S_ROT: begin
        cc.start = 1'b1;
        state_d = S_ROT_WAIT;
      end
      S_ROT_WAIT: begin
        if (cs.done) begin
          state_d = S_GAIN_X;
        end
      end
      S_GAIN_X: begin
        prod_d = PW'(c_xo) * GAIN_S;
        state_d = S_GAIN_Y;
      end
      S_GAIN_Y: begin
        xmm_d = mm_c;
        prod_d = PW'(c_yo) * GAIN_S;
        state_d = S_GAIN_END;
      end
      S_GAIN_END: begin
        ymm_d = mm_c;
        state_d = (seen_q >= w_eff) ? S_RD_OLD : S_STORE;
      end
      S_RD_OLD: begin
        dl_raddr = old_addr;
        state_d = S_RD_MID;
      end
      S_RD_MID: begin
        dl_raddr = mid_addr;
        dx_d = DW'(xmm_q) - DW'(old_x);
        dy_d = DW'(ymm_q) - DW'(old_y);
        state_d = S_VEC;
      end
      S_VEC: begin
        vote_d = rw_q ? mid_rng : RANGE_BITS'(1);
        if ((dx_q == 0) && (dy_q == 0)) begin
          bin_d = '0;
          state_d = S_HIST_RD;
        end else begin
          cc.start = 1'b1;
          cc.mode = CM_VECTOR;
          c_xi = vx;
          c_yi = vy;
          c_zi = vz;
          state_d = S_VEC_WAIT;
        end
      end
      S_VEC_WAIT: begin
        if (cs.done) begin
          state_d = S_BIN;
        end
      end
      S_BIN: begin
        bin_d = (zp >= ZPW'(NUM_BINS)) ? '0 : BW'(zp);
        state_d = S_HIST_RD;
      end
      S_HIST_RD: begin
        h_raddr = bin_q;
        state_d = S_HIST_WR;
      end
      S_HIST_WR: begin
        h_we = 1'b1;
        pair_d = 1'b1;
        state_d = S_STORE;
      end
      S_STORE: begin
        dl_we = 1'b1;
        wp_d = (wp_q == AW'(MAX_OFFSET - 1)) ? '0 : wp_q + 1'b1;
        if (seen_q < SW'(MAX_OFFSET)) begin
          seen_d = seen_q + 1'b1;
        end
        state_d = in_q.last_point ? S_END : S_IDLE;
      end
      S_END: begin
        if (pair_q) begin
          maxv_d = '0;
          mi_d = '0;
          cnt_d = '0;
          addr_d = '0;
          state_d = S_MAX;
        end else begin
          res_d = '0;
          res_d.too_few_points = 1'b1;
          state_d = S_OUT;
        end
      end
      S_MAX: begin
        if (pend_q && (h_eff > maxv_q)) begin
          maxv_d = h_eff;
          mi_d = baddr_q;
        end
        if ((cnt_q == walk_len) && !pend_q) begin
          cnt_d = '0;
          addr_d = '0;
          total_d = '0;
          state_d = S_TOTAL;
        end
      end
      S_TOTAL: begin
        if (pend_q) begin
          total_d = sat_add32(total_q, hf);
        end
        if ((cnt_q == walk_len) && !pend_q) begin
          cnt_d = '0;
          addr_d = peak_start;
          peak_d = '0;
          state_d = S_PEAK;
        end
      end
      S_PEAK: begin
        if (pend_q) begin
          peak_d = sat_add32(peak_q, hf);
        end
        if ((cnt_q == walk_len) && !pend_q) begin
          cnt_d = '0;
          addr_d = BW'(NUM_BINS - 1);
          best_d = '0;
          bi_d = '0;
          w1_d = '0;
          w2_d = '0;
          state_d = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        if (pend_q) begin
          if ((pidx_q >= CNTW'(2)) && (ssum > best_q)) begin
            best_d = ssum;
            bi_d = BW'(pidx_q - CNTW'(2));
          end
          w1_d = w2_q;
          w2_d = hf;
        end
        if ((cnt_q == walk_len) && !pend_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_d.corridor_like = (total_q != 32'd0) && (lhs >= rhs);
        res_d.peak_bin = 8'(bi_q);
        res_d.peak_weight = peak_q;
        res_d.total_weight = total_q;
        res_d.too_few_points = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_data_d = res_q;
          out_valid_d = 1'b1;
          hclr = 1'b1;
          seen_d = '0;
          pair_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seen_q <= '0;
      pair_q <= 1'b0;
      wp_q <= '0;
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
      hvalid_q <= '0;
      rw_q <= 1'b0;
      po_q <= 5'd2;
      phw_q <= 7'd25;
      mpf_q <= 9'd192;
    end else begin
      state_q <= state_d;
      seen_q <= seen_d;
      pair_q <= pair_d;
      wp_q <= wp_d;
      out_valid_q <= out_valid_d;
      pend_q <= pend_d;
      if (hclr) begin
        hvalid_q <= '0;
      end else if (h_we) begin
        hvalid_q[bin_q] <= 1'b1;
      end
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_RANGE_WEIGHTED:  rw_q <= pwdata[0];
          REG_PAIR_OFFSET:     po_q <= pwdata[4:0];
          REG_PEAK_HALF_WIDTH: phw_q <= pwdata[6:0];
          REG_MIN_PEAK_FRAC:   mpf_q <= pwdata[8:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    out_data_q <= out_data_d;
    res_q <= res_d;
    prod_q <= prod_d;
    xmm_q <= xmm_d;
    ymm_q <= ymm_d;
    dx_q <= dx_d;
    dy_q <= dy_d;
    vote_q <= vote_d;
    bin_q <= bin_d;
    cnt_q <= cnt_d;
    pidx_q <= pidx_d;
    addr_q <= addr_d;
    baddr_q <= baddr_d;
    maxv_q <= maxv_d;
    total_q <= total_d;
    peak_q <= peak_d;
    w1_q <= w1_d;
    w2_q <= w2_d;
    best_q <= best_d;
    mi_q <= mi_d;
    bi_q <= bi_d;
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_mem[bin_q] <= h_wdata;
    end
    h_rd_q <= hist_mem[h_raddr];
    hv_rd_q <= hvalid_q[h_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[wp_q] <= {rng, xmm_q, ymm_q};
    end
    dl_rd_q <= dl_mem[dl_raddr];
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RANGE_WEIGHTED:  prdata = 32'(rw_q);
      REG_PAIR_OFFSET:     prdata = 32'(po_q);
      REG_PEAK_HALF_WIDTH: prdata = 32'(phw_q);
      REG_MIN_PEAK_FRAC:   prdata = 32'(mpf_q);
    endcase
  end

  assign pready = 1'b1;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  a_too_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_few_points |->
      !out_data_o.corridor_like && (out_data_o.peak_weight == 32'd0) &&
      (out_data_o.total_weight == 32'd0) && (out_data_o.peak_bin == 8'd0))
    else $error("Too-few-points result carries nonzero fields.");

  a_peak_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.peak_weight <= out_data_o.total_weight))
    else $error("Peak window weight exceeds total weight.");

  a_corridor_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.corridor_like |-> (out_data_o.total_weight != 32'd0))
    else $error("Corridor reported on an empty histogram.");

  a_cordic_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !cs.busy)
    else $error("CORDIC unit busy while no point is in work.");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scan corridor angle histogram core. Scans of
// laser points are driven through the input channel while a local model of
// the CORDIC conversion, pair voting and histogram reduction predicts each
// scan result, which is compared field by field with what the core returns.
// ----------------------------------------------------------------------------
module tb;
  import scah_pkg::*;

  localparam int NB = 180;
  localparam int MO = 16;
  localparam int LIMIT = 1500000;

  typedef struct {
    in_t  pt;
    bit   typed;
    out_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  out_t        scan_results_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_off = 0;

  bit          weighted;
  bit [4:0]    offset_reg;
  bit [6:0]    half_width;
  bit [8:0]    frac_reg;
  longint      dl_rng[MO];
  longint      dl_x[MO];
  longint      dl_y[MO];
  bit [31:0]   hist[NB];
  int          seen;
  bit          paired;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  scan_corridor_angle_histogram_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  function automatic longint atan_step(int i);
    longint t[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                      41, 20, 10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  function automatic bit [31:0] sat32(bit [31:0] a, longint b);
    longint s;
    s = longint'(a) + b;
    return (s > 64'sh0FFFFFFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic longint gain_mm(longint v);
    longint lim, r;
    lim = (64'sd1 <<< 17) - 1;
    r = (v * 39797 + (64'sd1 <<< 17)) >>> 18;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  task automatic to_xy(longint r, longint ang, output longint xo, output longint yo);
    longint x, y, z, xs, ys;
    x = r * 4;
    y = 0;
    z = ang;
    if (z > 16384) begin
      z -= 32768;
      x = -x;
    end else if (z < -16384) begin
      z += 32768;
      x = -x;
    end
    for (int i = 0; i < 16; i++) begin
      ys = y >>> i;
      xs = x >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    xo = gain_mm(x);
    yo = gain_mm(y);
  endtask

  function automatic int dir_bin(longint dx, longint dy);
    longint x, y, z, xs, ys, t, b;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dy < 0 || (dy == 0 && dx < 0)) begin
      dx = -dx; dy = -dy;
    end
    x = dx * 16;
    y = dy * 16;
    if (x < 0) begin
      t = x; x = y; y = -t; z = 16384;
    end
    for (int i = 0; i < 16; i++) begin
      ys = y >>> i;
      xs = x >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    if (z < 0) z = 0;
    b = (z * NB + 16384) >>> 15;
    if (b >= NB) b = 0;
    return int'(b);
  endfunction

  task automatic clear_scan();
    foreach (hist[i]) hist[i] = '0;
    seen = 0;
    paired = 1'b0;
  endtask

  task automatic predict_point(in_t d, output bit has, output out_t r);
    int w, hw, mi, bi, b;
    longint x, y, maxv, s, best;
    bit [31:0] total, peak;
    longint frac;
    has = 1'b0;
    r = '0;
    w = offset_reg;
    if (w < 1) w = 1;
    if (w > MO) w = MO;
    if (d.point_valid) begin
      to_xy(longint'(d.range_mm), longint'(d.bearing), x, y);
      if (seen >= w) begin
        b = dir_bin(x - dl_x[w-1], y - dl_y[w-1]);
        hist[b] = sat32(hist[b], weighted ? dl_rng[w - w/2 - 1] : 1);
        paired = 1'b1;
      end
      for (int i = MO-1; i > 0; i--) begin
        dl_rng[i] = dl_rng[i-1]; dl_x[i] = dl_x[i-1]; dl_y[i] = dl_y[i-1];
      end
      dl_rng[0] = d.range_mm; dl_x[0] = x; dl_y[0] = y;
      if (seen < MO) seen++;
    end
    if (!d.last_point) return;
    has = 1'b1;
    if (!paired) begin
      r.too_few_points = 1'b1;
      clear_scan();
      return;
    end
    maxv = 0; mi = -1; total = 0; peak = 0;
    for (int i = 0; i < NB; i++)
      if (hist[i] > maxv) begin
        maxv = hist[i]; mi = i;
      end
    for (int i = 0; i < NB; i++)
      if (longint'(hist[i]) * 20 < maxv) hist[i] = 0;
      else total = sat32(total, hist[i]);
    hw = half_width;
    if (hw > (NB-1)/2) hw = (NB-1)/2;
    if (mi >= 0)
      for (int k = -hw; k <= hw; k++) peak = sat32(peak, hist[(mi + k + NB) % NB]);
    frac = (frac_reg > 256) ? 256 : frac_reg;
    best = 0; bi = 0;
    for (int i = 0; i < NB; i++) begin
      s = longint'(hist[(i == 0) ? NB-1 : i-1]) + hist[i] + hist[(i+1 == NB) ? 0 : i+1];
      if (s > best) begin
        best = s; bi = i;
      end
    end
    r.corridor_like = (total != 0 && longint'(peak) * 256 >= frac * longint'(total));
    r.peak_bin = bi[7:0];
    r.peak_weight = peak;
    r.total_weight = total;
    clear_scan();
  endtask

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  task automatic queue_result(out_t r);
    scan_results_q = {scan_results_q, r};
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_RANGE_WEIGHTED:  weighted = val[0];
      REG_PAIR_OFFSET:     offset_reg = val[4:0];
      REG_PEAK_HALF_WIDTH: half_width = val[6:0];
      default:             frac_reg = val[8:0];
    endcase
  endtask

  task automatic set_config(bit rw, int off, int hw, int fr);
    reg_write(REG_RANGE_WEIGHTED, 32'(rw));
    reg_write(REG_PAIR_OFFSET, off);
    reg_write(REG_PEAK_HALF_WIDTH, hw);
    reg_write(REG_MIN_PEAK_FRAC, fr);
  endtask

  task automatic send_point(in_t d, bit typed, out_t res);
    bit has;
    out_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (in_stall);
    predict_point(d, has, r);
    if (typed) queue_result(res);
    else if (has) queue_result(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (scan_results_q.size() == 0);
    repeat (1000) @(posedge clk);
  endtask

  task automatic random_scan(int npts);
    in_t d;
    int base, step;
    bit structured;
    structured = $urandom_range(0, 3) != 0;
    base = $urandom_range(200, 8000);
    step = $urandom_range(20, 600);
    d.bearing = 16'($urandom);
    for (int i = 0; i < npts; i++) begin
      if (structured) begin
        d.range_mm = 16'(base + $urandom_range(0, 40));
        d.bearing = 16'(d.bearing + step);
        d.point_valid = $urandom_range(0, 9) != 0;
      end else begin
        d.range_mm = 16'($urandom);
        d.bearing = 16'($urandom);
        d.point_valid = $urandom_range(0, 2) != 0;
      end
      d.last_point = (i == npts - 1);
      send_point(d, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_idle;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (scan_results_q.size() == 0) begin
        report("unexpected transfer", 1, 0);
      end else begin
        want = scan_results_q.pop_front();
        if (out_data.corridor_like !== want.corridor_like)
          report("corridor_like", out_data.corridor_like, want.corridor_like);
        if (out_data.peak_bin !== want.peak_bin)
          report("peak_bin", out_data.peak_bin, want.peak_bin);
        if (out_data.peak_weight !== want.peak_weight)
          report("peak_weight", out_data.peak_weight, want.peak_weight);
        if (out_data.total_weight !== want.total_weight)
          report("total_weight", out_data.total_weight, want.total_weight);
        if (out_data.too_few_points !== want.too_few_points)
          report("too_few_points", out_data.too_few_points, want.too_few_points);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    out_t few;
    int total_pts;
    few = '0;
    few.too_few_points = 1'b1;
    rows = '{
      '{'{16'd1000, 16'sd0, 1'b1, 1'b1}, 1'b1, few},
      '{'{16'd0, 16'sd0, 1'b0, 1'b1}, 1'b1, few},
      '{'{16'hFFFF, 16'sh8000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'hFFFF, 16'sh7FFF, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd0, 16'sd16384, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'h1234, 16'sd100, 1'b0, 1'b0}, 1'b0, '0},
      '{'{16'd500, 16'sd16385, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd500, 16'sd16385, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd500, 16'sd16385, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd3000, -16'sd16385, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd3000, -16'sd16000, 1'b1, 1'b1}, 1'b0, '0},
      '{'{16'd2000, 16'sd1000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd2000, 16'sd1000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd2000, 16'sd1000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{16'd2000, 16'sd1000, 1'b0, 1'b1}, 1'b0, '0}
    };
    weighted = 1'b0; offset_reg = 5'd2; half_width = 7'd25; frac_reg = 9'd192;
    foreach (dl_rng[i]) begin
      dl_rng[i] = 0; dl_x[i] = 0; dl_y[i] = 0;
    end
    clear_scan();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].res);
    drain();
    set_config(1'b1, 1, 0, 0);
    foreach (rows[i]) if (i >= 2) send_point(rows[i].pt, 1'b0, '0);
    drain();
    set_config(1'b1, 16, 89, 256);
    random_scan(24);
    drain();
    set_config(1'b0, 0, 127, 511);
    random_scan(12);
    drain();
    set_config(1'b1, 31, 100, 300);
    random_scan(24);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle = (ph < 3) ? 16 : (ph < 6) ? 49 : 0;
      recv_idle = (ph < 3) ? 49 : (ph < 6) ? 16 : 0;
      if (ph == 0) set_config(1'b0, 2, 25, 192);
      else if (ph == 7) set_config(1'b1, 16, 89, 256);
      else set_config(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                      $urandom_range(0, 127), $urandom_range(0, 511));
      if (ph == 1) hold_off = 3000;
      total_pts = 0;
      while (total_pts < 200) begin
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        random_scan(n);
        total_pts += n;
      end
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
